### rtl/core/bpps_pkg.sv
package bpps_pkg;

    // Width of one routed word; bit 0 picks the output port.
    localparam int WORD_W = 32;

    // Slave-side item: first_valid, first_word, second_valid, second_word.
    localparam int S_FIELD_W = 2 * WORD_W + 2;
    localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;

    // Master-side item: odd_valid, odd_word, even_valid, even_word,
    // first_accepted, second_accepted.
    localparam int M_FIELD_W = 2 * WORD_W + 4;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // Bit positions in the master-side tdata.
    localparam int M_ODD_VALID_BIT  = 0;
    localparam int M_ODD_WORD_LSB   = 1;
    localparam int M_EVEN_VALID_BIT = WORD_W + 1;
    localparam int M_EVEN_WORD_LSB  = WORD_W + 2;

    // A buffered word with its occupancy flag.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_slot;

    // Head-pop requests from the crossbar back to the two queues.
    typedef struct packed {
        logic one;
        logic two;
    } t_pop;

    // Output-port view of one step.
    typedef struct packed {
        logic              odd_valid;
        logic [WORD_W-1:0] odd_word;
        logic              even_valid;
        logic [WORD_W-1:0] even_word;
    } t_route;

endpackage

### rtl/core/bpps_fifo.sv
module bpps_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_push_valid,
    input  logic [bpps_pkg::WORD_W-1:0]   i_push_word,
    input  logic                          i_pop,
    output bpps_pkg::t_slot               o_head,
    output logic                          o_accepted
);
    import bpps_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_X    = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX   = AW'(DEPTH - 1);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] r_byp;
    logic              r_use_byp;

    logic              push;
    logic              pop;
    logic [AW-1:0]     head_inc;
    logic [AW:0]       wr_sum;
    logic [AW-1:0]     wr_idx;
    logic [AW-1:0]     n_head;
    logic [CW-1:0]     n_count;
    logic              byp;
    logic [AW-1:0]     rd_addr;

    always_comb begin
        push     = i_push_valid && (r_count != FULL_COUNT);
        pop      = i_pop && (r_count != '0);
        head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        wr_sum   = {1'b0, r_head} + (AW + 1)'(r_count);
        wr_idx   = (wr_sum >= DEPTH_X) ? AW'(wr_sum - DEPTH_X) : AW'(wr_sum);
        n_head   = pop ? head_inc : r_head;
        n_count  = r_count + CW'(push) - CW'(pop);
        // the word written this step lands on the new head: forward it
        byp      = push && (r_count == CW'(pop));
        rd_addr  = i_step ? n_head : r_head;
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_use_byp ? r_byp : r_rd;
    assign o_accepted   = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_use_byp <= 1'b0;
        end else if (i_step) begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_use_byp <= byp;
        end else begin
            r_use_byp <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && push) begin
            r_mem[wr_idx] <= i_push_word;
        end
        if (i_step && byp) begin
            r_byp <= i_push_word;
        end
        r_rd <= r_mem[rd_addr];
    end

endmodule

### rtl/core/bpps_xbar.sv
module bpps_xbar (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  bpps_pkg::t_slot  i_head_one,
    input  bpps_pkg::t_slot  i_head_two,
    output bpps_pkg::t_pop   o_pop,
    output bpps_pkg::t_route o_route
);
    import bpps_pkg::*;

    localparam int REQ_ONE_ODD  = 0;
    localparam int REQ_TWO_ODD  = 1;
    localparam int REQ_ONE_EVEN = 2;
    localparam int REQ_TWO_EVEN = 3;

    t_slot             r_latch_one;
    t_slot             r_latch_two;
    logic [3:0]        r_req;
    logic [WORD_W-1:0] r_last_odd;
    logic [WORD_W-1:0] r_last_even;

    t_slot             n_latch_one;
    t_slot             n_latch_two;
    logic [3:0]        n_req;
    logic [WORD_W-1:0] n_last_odd;
    logic [WORD_W-1:0] n_last_even;
    logic              free_one;
    logic              free_two;
    logic              odd_v;
    logic              even_v;
    logic              keep_one;
    logic              keep_two;
    logic              pop_one;
    logic              pop_two;

    always_comb begin
        odd_v    = r_req[REQ_ONE_ODD] | r_req[REQ_TWO_ODD];
        even_v   = r_req[REQ_ONE_EVEN] | r_req[REQ_TWO_EVEN];
        free_one = r_req[REQ_ONE_ODD] | r_req[REQ_ONE_EVEN];
        free_two = (!r_req[REQ_ONE_ODD] && r_req[REQ_TWO_ODD])
                 | (!r_req[REQ_ONE_EVEN] && r_req[REQ_TWO_EVEN]);

        n_last_odd  = r_last_odd;
        n_last_even = r_last_even;
        if (odd_v) begin
            n_last_odd = r_req[REQ_ONE_ODD] ? r_latch_one.word : r_latch_two.word;
        end
        if (even_v) begin
            n_last_even = r_req[REQ_ONE_EVEN] ? r_latch_one.word : r_latch_two.word;
        end

        // a granted latch takes a fresh head word in the same step
        keep_one = r_latch_one.valid && !free_one;
        keep_two = r_latch_two.valid && !free_two;
        pop_one  = i_head_one.valid && !keep_one;
        pop_two  = i_head_two.valid && !keep_two;

        n_latch_one.valid = keep_one | pop_one;
        n_latch_one.word  = pop_one ? i_head_one.word : r_latch_one.word;
        n_latch_two.valid = keep_two | pop_two;
        n_latch_two.word  = pop_two ? i_head_two.word : r_latch_two.word;

        n_req = '0;
        if (n_latch_one.valid && n_latch_one.word[0]) begin
            n_req[REQ_ONE_ODD] = 1'b1;
        end else if (n_latch_two.valid && n_latch_two.word[0]) begin
            n_req[REQ_TWO_ODD] = 1'b1;
        end
        if (n_latch_one.valid && !n_latch_one.word[0]) begin
            n_req[REQ_ONE_EVEN] = 1'b1;
        end else if (n_latch_two.valid && !n_latch_two.word[0]) begin
            n_req[REQ_TWO_EVEN] = 1'b1;
        end
    end

    assign o_pop.one          = pop_one;
    assign o_pop.two          = pop_two;
    assign o_route.odd_valid  = odd_v;
    assign o_route.odd_word   = n_last_odd;
    assign o_route.even_valid = even_v;
    assign o_route.even_word  = n_last_even;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch_one <= '0;
            r_latch_two <= '0;
            r_req       <= '0;
            r_last_odd  <= '0;
            r_last_even <= '0;
        end else if (i_step) begin
            r_latch_one <= n_latch_one;
            r_latch_two <= n_latch_two;
            r_req       <= n_req;
            r_last_odd  <= n_last_odd;
            r_last_even <= n_last_even;
        end
    end

endmodule

### rtl/core/buffered_two_port_parity_switch.sv
// Two-input, two-output switch that steers each word by its lowest bit:
// odd words leave on the odd port, even words on the even port.
// Slave channel (s_*): one item per switch step, carrying both input
//   ports' valid flags and words. Every accepted item advances the switch
//   by one step and produces exactly one item on the master channel.
// Master channel (m_*): per-port valid flags, port words (the last word
//   sent when a port is idle), and one accept flag per input queue.
// The result for an item appears on m_* in the cycle after the item
//   is taken. Throughput: one item per clock; s_tready stays high
//   while the result register is empty or being drained in that cycle.
// Inside, a word goes input queue -> per-input latch -> request register
//   -> output port, so a word first shows on an output two items after
//   the one that brought it in, when no conflict holds it back.
// Input one has fixed priority when both latches want the same port.
// A full queue drops the offered word and clears its accept flag.
// Reset (synchronous, active low) empties the queues, latches and request
//   register, zeroes the held port words and drops m_tvalid.
// When the receiver stalls, hold the result and stop taking items; the
//   switch state stands still until the result is taken.
module buffered_two_port_parity_switch #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] first_valid, [32:1] first_word, [33] second_valid,
    // [65:34] second_word, [71:66] zero
    input  logic [bpps_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] odd_valid, [32:1] odd_word, [33] even_valid, [65:34] even_word,
    // [66] first_accepted, [67] second_accepted, [71:68] zero
    output logic [bpps_pkg::M_DATA_W-1:0]  m_tdata
);
    import bpps_pkg::*;

    // unpack the incoming item
    logic              first_valid;
    logic [WORD_W-1:0] first_word;
    logic              second_valid;
    logic [WORD_W-1:0] second_word;

    assign first_valid  = s_tdata[0];
    assign first_word   = s_tdata[WORD_W:1];
    assign second_valid = s_tdata[WORD_W+1];
    assign second_word  = s_tdata[2*WORD_W+1:WORD_W+2];

    // result register decouples the two sides
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic                step;

    assign s_tready = !r_out_valid || m_tready;
    assign step     = s_tvalid && s_tready;

    t_slot  head_one;
    t_slot  head_two;
    t_pop   pop;
    t_route route;
    logic   first_acc;
    logic   second_acc;

    bpps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo_one (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_push_valid (first_valid),
        .i_push_word  (first_word),
        .i_pop        (pop.one),
        .o_head       (head_one),
        .o_accepted   (first_acc)
    );

    bpps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo_two (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_push_valid (second_valid),
        .i_push_word  (second_word),
        .i_pop        (pop.two),
        .o_head       (head_two),
        .o_accepted   (second_acc)
    );

    bpps_xbar u_xbar (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_head_one (head_one),
        .i_head_two (head_two),
        .o_pop      (pop),
        .o_route    (route)
    );

    // Load a fresh result on every step; drop valid once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= M_DATA_W'({second_acc, first_acc,
                                     route.even_word, route.even_valid,
                                     route.odd_word, route.odd_valid});
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

### rtl/core/bpps_checker.sv
module bpps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bpps_pkg::M_DATA_W-1:0] m_tdata
);
    import bpps_pkg::*;

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no item taken while a result waits unread
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("item accepted over a waiting result");

    // every item taken gives a result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("missing result");

    // parity steering
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |->
            (!m_tdata[M_ODD_VALID_BIT] || m_tdata[M_ODD_WORD_LSB]) &&
            (!m_tdata[M_EVEN_VALID_BIT] || !m_tdata[M_EVEN_WORD_LSB]))
        else $error("word on the wrong port");

endmodule

bind buffered_two_port_parity_switch bpps_checker u_bpps_checker (.*);
